// File: sv/shooter_fire_mode_controller_assert.svh
// Assertion macros for the fire-mode controller.
`ifndef SHOOTER_FIRE_MODE_CONTROLLER_ASSERT_SVH
`define SHOOTER_FIRE_MODE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SFMC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sfmc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SFMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sfmc: next-cycle check failed");

`endif

// File: sv/sfmc_pkg.sv
`default_nettype none

package sfmc_pkg;

    typedef enum logic [2:0] {
        M_STOP    = 3'd0,
        M_RFRIC   = 3'd1,
        M_RBULLET = 3'd2,
        M_READY   = 3'd3,
        M_BULLET  = 3'd4,
        M_CONT    = 3'd5,
        M_DONE    = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        SPD_ZERO   = 2'd0,
        SPD_READY  = 2'd1,
        SPD_SINGLE = 2'd2,
        SPD_CONT   = 2'd3
    } t_speed_sel;

    // lever codes
    localparam logic [1:0] SW_STOP  = 2'd0;
    localparam logic [1:0] SW_SPIN  = 2'd1;
    localparam logic [1:0] SW_FIRE  = 2'd2;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_TICK_MS      = 3'd0;
    localparam logic [2:0] REG_LONG_PRESS   = 3'd1;
    localparam logic [2:0] REG_DONE_KEY_OFF = 3'd2;
    localparam logic [2:0] REG_BLOCK        = 3'd3;
    localparam logic [2:0] REG_REVERSE      = 3'd4;

    localparam logic [7:0]  TICK_MS_RST      = 8'd1;
    localparam logic [15:0] LONG_PRESS_RST   = 16'd500;
    localparam logic [15:0] DONE_KEY_OFF_RST = 16'd100;
    localparam logic [15:0] BLOCK_RST        = 16'd500;
    localparam logic [15:0] REVERSE_RST      = 16'd100;

    typedef struct packed {
        logic [1:0] switch_pos;
        logic       link_online;
        logic       entertain;
        logic [1:0] permit;
        logic       trigger_key;
        logic       mouse_left;
        logic       mouse_right;
        logic       wheels_ready;
        logic       heat_over;
        logic       gimbal_stop;
        logic       trigger_stalled;
        logic       angle_reached;
    } t_in_word;

    typedef struct packed {
        t_mode      mode;
        t_speed_sel trigger_speed_sel;
        logic       trigger_reverse;
        logic       trigger_drive_on;
        logic       fric_on;
        logic       capture_target;
    } t_out_word;

endpackage

`default_nettype wire

// File: sv/shooter_fire_mode_controller.sv
// Flow: an accepted word is held in the input register, processed by one pass of
//   logic into the result register and offered on the output from there.
// Throughput: one word per cycle unless the output stalls; the input register is refilled in the same
//   cycle as it drains, and the output register holds its result through downstream stalls.
// Reset: i_rst_n synchronous, active low; clears sequencer, timers, fire gate,
//   trigger drive state and valids, and loads the register defaults.
`default_nettype none

`include "shooter_fire_mode_controller_assert.svh"

module shooter_fire_mode_controller #(
    parameter int unsigned TIMER_BITS = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // input channel
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  sfmc_pkg::t_in_word    i_in_data,
    // output channel
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output sfmc_pkg::t_out_word   o_out_data,
    // register port
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [4:0]            paddr,
    input  wire  [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import sfmc_pkg::*;

    // compare width: covers both the timers and the 16-bit limits, plus carry
    localparam int unsigned CW = ((TIMER_BITS > 16) ? TIMER_BITS : 16) + 1;

    typedef logic [TIMER_BITS-1:0] t_timer;

    // saturating timer add: stops at min(limit, timer max); a tick of 0 counts as 1
    function automatic t_timer sat_add(input t_timer v, input logic [15:0] lim,
                                       input logic [7:0] tick);
        logic [CW-1:0] lim_x;
        logic [CW-1:0] tmax;
        logic [CW-1:0] l;
        logic [CW-1:0] n;
        lim_x = CW'(lim);
        tmax  = CW'({TIMER_BITS{1'b1}});
        l     = (lim_x < tmax) ? lim_x : tmax;
        n     = CW'(v) + ((tick == 8'd0) ? CW'(1) : CW'(tick));
        return TIMER_BITS'((n >= l) ? l : n);
    endfunction

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    logic [7:0]  r_tick_ms;
    logic [15:0] r_long_press_ms;
    logic [15:0] r_done_key_off_ms;
    logic [15:0] r_block_ms;
    logic [15:0] r_reverse_ms;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_ms         <= TICK_MS_RST;
            r_long_press_ms   <= LONG_PRESS_RST;
            r_done_key_off_ms <= DONE_KEY_OFF_RST;
            r_block_ms        <= BLOCK_RST;
            r_reverse_ms      <= REVERSE_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_TICK_MS:      r_tick_ms         <= pwdata[7:0];
                REG_LONG_PRESS:   r_long_press_ms   <= pwdata[15:0];
                REG_DONE_KEY_OFF: r_done_key_off_ms <= pwdata[15:0];
                REG_BLOCK:        r_block_ms        <= pwdata[15:0];
                REG_REVERSE:      r_reverse_ms      <= pwdata[15:0];
                default: ;  // unmapped: ignored
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_TICK_MS:      prdata = {24'd0, r_tick_ms};
            REG_LONG_PRESS:   prdata = {16'd0, r_long_press_ms};
            REG_DONE_KEY_OFF: prdata = {16'd0, r_done_key_off_ms};
            REG_BLOCK:        prdata = {16'd0, r_block_ms};
            REG_REVERSE:      prdata = {16'd0, r_reverse_ms};
            default:          prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: input register -> one pass of logic -> result register
    // ------------------------------------------------------------------
    t_in_word  r_in;
    logic      r_in_valid;
    t_out_word r_out;
    logic      r_out_valid;
    t_out_word n_out;
    logic      stage_go;
    logic      in_take;

    // the stage moves whenever the input register holds a word and the result register is free or being emptied
    assign stage_go    = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall  = r_in_valid && r_out_valid && i_out_stall;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= in_take || (r_in_valid && !stage_go);
            r_out_valid <= stage_go || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (stage_go) begin
            r_out <= n_out;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    t_mode      r_mode,        n_mode;
    logic       r_key_seen,    n_key_seen;
    logic [1:0] r_press_now,   n_press_now;
    logic [1:0] r_press_before, n_press_before;
    t_timer     r_press_l,     n_press_l;
    t_timer     r_press_r,     n_press_r;
    t_timer     r_key_off,     n_key_off;
    t_timer     r_stall,       n_stall;
    t_timer     r_reverse,     n_reverse;
    logic       r_shot_moving, n_shot_moving;
    logic       r_g_inited,    n_g_inited;
    logic       r_g_engaged,   n_g_engaged;
    logic       r_g_last_fire, n_g_last_fire;
    t_speed_sel r_hold_sel,    n_hold_sel;
    logic       r_hold_rev,    n_hold_rev;
    logic       r_ent_seen,    n_ent_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= M_STOP;
            r_key_seen     <= 1'b0;
            r_press_now    <= 2'd0;
            r_press_before <= 2'd0;
            r_press_l      <= '0;
            r_press_r      <= '0;
            r_key_off      <= '0;
            r_stall        <= '0;
            r_reverse      <= '0;
            r_shot_moving  <= 1'b0;
            r_g_inited     <= 1'b0;
            r_g_engaged    <= 1'b0;
            r_g_last_fire  <= 1'b0;
            r_hold_sel     <= SPD_ZERO;
            r_hold_rev     <= 1'b0;
            r_ent_seen     <= 1'b0;
        end else if (stage_go) begin
            r_mode         <= n_mode;
            r_key_seen     <= n_key_seen;
            r_press_now    <= n_press_now;
            r_press_before <= n_press_before;
            r_press_l      <= n_press_l;
            r_press_r      <= n_press_r;
            r_key_off      <= n_key_off;
            r_stall        <= n_stall;
            r_reverse      <= n_reverse;
            r_shot_moving  <= n_shot_moving;
            r_g_inited     <= n_g_inited;
            r_g_engaged    <= n_g_engaged;
            r_g_last_fire  <= n_g_last_fire;
            r_hold_sel     <= n_hold_sel;
            r_hold_rev     <= n_hold_rev;
            r_ent_seen     <= n_ent_seen;
        end
    end

    // Jam logic: stall time only ever comes from the register here, so the
    // drive-with-jam outcome can be worked out once up front.
    logic   jammed;
    t_timer jam_stall;
    t_timer jam_reverse;

    always_comb begin
        jammed      = CW'(r_stall) >= CW'(r_block_ms);
        jam_stall   = r_stall;
        jam_reverse = r_reverse;
        if (r_in.trigger_stalled && !jammed) begin
            jam_stall   = sat_add(r_stall, r_block_ms, r_tick_ms);
            jam_reverse = '0;
        end else if (jammed && (CW'(r_reverse) < CW'(r_reverse_ms))) begin
            jam_reverse = sat_add(r_reverse, r_reverse_ms, r_tick_ms);
        end else begin
            jam_stall   = '0;
        end
    end

    // Main pass
    logic raw_fire;
    logic eff_fire;
    logic a_fric;
    logic a_trig;
    logic capture;
    logic drive_on;
    logic fric_on;
    logic clear_trig;
    logic use_jam;

    assign raw_fire = (r_in.switch_pos == SW_FIRE);
    assign a_fric   = r_in.permit[0];
    assign a_trig   = r_in.permit[1];

    always_comb begin
        n_mode         = r_mode;
        n_key_seen     = r_key_seen;
        n_press_now    = r_press_now;
        n_press_before = r_press_before;
        n_press_l      = r_press_l;
        n_press_r      = r_press_r;
        n_key_off      = r_key_off;
        n_stall        = r_stall;
        n_reverse      = r_reverse;
        n_shot_moving  = r_shot_moving;
        n_g_inited     = r_g_inited;
        n_g_engaged    = r_g_engaged;
        n_g_last_fire  = r_g_last_fire;
        n_hold_sel     = r_hold_sel;
        n_hold_rev     = r_hold_rev;
        n_ent_seen     = 1'b0;
        eff_fire       = raw_fire;
        capture        = 1'b0;
        drive_on       = 1'b0;
        fric_on        = 1'b0;
        clear_trig     = 1'b0;
        use_jam        = 1'b0;
        n_out          = '0;

        if (r_in.entertain) begin
            // forced stop; everything else frozen, drive cleared on entry
            n_ent_seen = 1'b1;
            n_mode     = M_STOP;
            clear_trig = !r_ent_seen;
        end else begin
            // --- sequencer, on last tick's key and buttons ---
            if (r_in.switch_pos == SW_STOP) begin
                n_mode = M_STOP;
            end else if (r_in.switch_pos == SW_SPIN || raw_fire) begin
                n_mode = M_RFRIC;
            end

            if (raw_fire && n_mode == M_RFRIC && (r_in.wheels_ready || (!a_fric && a_trig)))
            begin
                n_mode = M_RBULLET;
            end else if (n_mode == M_RBULLET && r_key_seen) begin
                n_mode = M_READY;
            end else if (n_mode == M_READY && !r_key_seen) begin
                n_mode = M_RBULLET;
            end else if (n_mode == M_READY) begin
                if ((r_press_now & ~r_press_before) != 2'd0) begin
                    n_mode = M_BULLET;
                end
            end else if (n_mode == M_DONE) begin
                if (!r_key_seen) begin
                    n_key_off = sat_add(r_key_off, r_done_key_off_ms, r_tick_ms);
                    if (CW'(n_key_off) >= CW'(r_done_key_off_ms)) begin
                        n_key_off = '0;
                        n_mode    = M_RBULLET;
                    end
                end else begin
                    n_key_off = '0;
                    n_mode    = M_BULLET;
                end
            end

            if (n_mode > M_RFRIC) begin
                if (CW'(r_press_l) == CW'(r_long_press_ms) ||
                    CW'(r_press_r) == CW'(r_long_press_ms)) begin
                    n_mode = M_CONT;
                end else if (n_mode == M_CONT) begin
                    n_mode = M_RBULLET;
                end
            end
            if (r_in.heat_over &&
                (n_mode == M_BULLET || n_mode == M_CONT || n_mode == M_READY)) begin
                n_mode = M_RBULLET;
            end
            if (r_in.gimbal_stop) begin
                n_mode = M_STOP;
            end
            if (!a_trig && n_mode > M_RFRIC) begin
                n_mode = M_RFRIC;
            end
            if (!a_fric && !a_trig) begin
                n_mode = M_STOP;
            end

            // --- sample key and buttons, press timers ---
            n_key_seen     = r_in.trigger_key;
            n_press_before = r_press_now;
            n_press_now    = {r_in.mouse_right, r_in.mouse_left};
            if (r_in.mouse_left) begin
                if (CW'(r_press_l) < CW'(r_long_press_ms)) begin
                    n_press_l = sat_add(r_press_l, r_long_press_ms, r_tick_ms);
                end
            end else begin
                n_press_l = '0;
            end
            if (r_in.mouse_right) begin
                if (CW'(r_press_r) < CW'(r_long_press_ms)) begin
                    n_press_r = sat_add(r_press_r, r_long_press_ms, r_tick_ms);
                end
            end else begin
                n_press_r = '0;
            end

            // --- fire gate: while the link is online, arms only on a lever move into fire ---
            if (!r_in.link_online) begin
                n_g_inited    = 1'b0;
                n_g_engaged   = 1'b0;
                n_g_last_fire = 1'b0;
                eff_fire      = raw_fire;
            end else begin
                n_g_inited = 1'b1;
                if (!r_g_inited) begin
                    n_g_engaged   = 1'b0;
                    n_g_last_fire = raw_fire;
                end
                if (!raw_fire) begin
                    n_g_engaged = 1'b0;
                end else if (!n_g_last_fire) begin
                    n_g_engaged = 1'b1;
                end
                eff_fire      = raw_fire && n_g_engaged;
                n_g_last_fire = raw_fire;
            end

            // --- trigger drive, on this tick's key ---
            if (n_mode == M_RBULLET) begin
                if (!r_in.trigger_key) begin
                    use_jam    = 1'b1;
                    n_hold_sel = SPD_READY;
                end else begin
                    n_hold_sel = SPD_ZERO;
                    n_hold_rev = 1'b0;
                end
            end else if (n_mode == M_BULLET) begin
                if (!r_shot_moving) begin
                    capture       = 1'b1;
                    n_shot_moving = 1'b1;
                end
                if (!r_in.trigger_key) begin
                    n_mode = M_DONE;
                end
                // capture tick: target is ahead, so never counts as reached
                if (capture || !r_in.angle_reached) begin
                    use_jam    = 1'b1;
                    n_hold_sel = SPD_SINGLE;
                end else begin
                    n_shot_moving = 1'b0;
                end
            end else if (n_mode == M_CONT) begin
                use_jam    = 1'b1;
                n_hold_sel = SPD_CONT;
            end else begin
                n_hold_sel = SPD_ZERO;
                n_hold_rev = 1'b0;
            end

            if (use_jam) begin
                n_hold_rev = jammed;
                n_stall    = jam_stall;
                n_reverse  = jam_reverse;
            end

            if (n_mode == M_STOP) begin
                clear_trig = 1'b1;
            end else begin
                drive_on = (n_mode >= M_RBULLET);
            end
            if (!a_trig || !eff_fire) begin
                clear_trig = 1'b1;
                drive_on   = 1'b0;
            end
            fric_on = a_fric && (n_mode != M_STOP);
        end

        if (clear_trig) begin
            n_hold_sel    = SPD_ZERO;
            n_hold_rev    = 1'b0;
            n_shot_moving = 1'b0;
            n_stall       = '0;
            n_reverse     = '0;
        end

        if (!r_in.entertain) begin
            n_out.mode              = n_mode;
            n_out.trigger_speed_sel = n_hold_sel;
            n_out.trigger_reverse   = n_hold_rev && (n_hold_sel != SPD_ZERO);
            n_out.trigger_drive_on  = drive_on;
            n_out.fric_on           = fric_on;
            n_out.capture_target    = capture;
        end
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // trigger current only in the armed modes
    `SFMC_ASSERT_NOW(a_drive_mode, i_clk, i_rst_n,
        r_out_valid && r_out.trigger_drive_on, r_out.mode >= M_RBULLET)
    // a new target is captured only while shooting a single round
    `SFMC_ASSERT_NOW(a_capture_mode, i_clk, i_rst_n,
        r_out_valid && r_out.capture_target,
        r_out.mode == M_BULLET || r_out.mode == M_DONE)
    // input held off only when an input word is held, a result is waiting and the sink is stalled
    `SFMC_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n,
        o_in_stall, r_in_valid && r_out_valid && i_out_stall)
    // a fired stage always leaves a result behind
    `SFMC_ASSERT_NEXT(a_stage_result, i_clk, i_rst_n, stage_go, r_out_valid)

endmodule

`default_nettype wire
